// ===== rtl/utf8_fold_and_truncate_top_assert.svh =====
// Assertion macros shared by the checker of the fold-and-truncate block.
// Both expect signals named clock and reset in the scope where they are used.
`ifndef UTF8_FOLD_AND_TRUNCATE_TOP_ASSERT_SVH
`define UTF8_FOLD_AND_TRUNCATE_TOP_ASSERT_SVH

// Same-cycle implication, quiet while reset is high
`define UFT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, quiet while reset is high
`define UFT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/utf8ft_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package utf8ft_pkg;

   // Sizing of the glyph chain
   localparam int MAX_COLS = 32;
   localparam int CELLS    = MAX_COLS + 1;
   localparam int IDX_W    = $clog2(CELLS);
   localparam int CNT_W    = $clog2(CELLS + 1);
   localparam int BYTE_W   = 8;
   localparam int GLYPH_W  = 7;
   localparam int CFG_W    = 6;

   localparam logic [CFG_W-1:0] MAX_GLYPHS_RST = 6'd21;

   // Byte codes
   localparam logic [BYTE_W-1:0] BYTE_NUL     = 8'h00;
   localparam logic [BYTE_W-1:0] BYTE_LEAD_C3 = 8'hC3;
   localparam logic [BYTE_W-1:0] BYTE_HIGH    = 8'h80;
   localparam logic [BYTE_W-1:0] BYTE_PRINT   = 8'h20;
   localparam logic [1:0]        CONT_TAG     = 2'b10;

   // Glyph codes
   localparam logic [GLYPH_W-1:0] GLYPH_NONE  = 7'h00;
   localparam logic [GLYPH_W-1:0] GLYPH_SPACE = 7'h20;
   localparam logic [GLYPH_W-1:0] GLYPH_COMMA = 7'h2C;
   localparam logic [GLYPH_W-1:0] GLYPH_HYPH  = 7'h2D;
   localparam logic [GLYPH_W-1:0] GLYPH_DOT   = 7'h2E;
   localparam logic [GLYPH_W-1:0] GLYPH_SEMI  = 7'h3B;
   localparam logic [GLYPH_W-1:0] GLYPH_QUERY = 7'h3F;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TRIM,
      ST_EMIT,
      ST_DOT,
      ST_EMPTY
   } state_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_WRITE,
      CELL_MARK,
      CELL_TRIM,
      CELL_SHIFT
   } cell_op_type;

   // Broadcast to every cell
   typedef struct packed {
      cell_op_type        op;
      logic [GLYPH_W-1:0] glyph;
   } cell_ctl_type;

   // What one cell hands to its lower neighbour
   typedef struct packed {
      logic [GLYPH_W-1:0] glyph;
      logic               keep;
      logic               tok;
   } cell_link_type;

   // Controller to chain
   typedef struct packed {
      cell_op_type        op;
      logic [GLYPH_W-1:0] glyph;
      logic [IDX_W-1:0]   wr_idx;
      logic [CNT_W-1:0]   mark_n;
      logic               mark_trim;
   } chain_cmd_type;

   // Chain to controller
   typedef struct packed {
      logic [GLYPH_W-1:0] glyph0;
      logic               keep0;
      logic               keep1;
      logic               tok_any;
   } chain_stat_type;

   // Second byte of a 0xC3 pair to its plain Latin letter
   function automatic logic [GLYPH_W-1:0] fold_latin(input logic [BYTE_W-1:0] b);
      logic [GLYPH_W-1:0] g;
      case (b)
         8'hA0, 8'hA1, 8'hA2, 8'hA4: g = 7'h61; // a
         8'h80, 8'h81, 8'h82, 8'h84: g = 7'h41; // A
         8'hA8, 8'hA9, 8'hAA, 8'hAB: g = 7'h65; // e
         8'h88, 8'h89, 8'h8A, 8'h8B: g = 7'h45; // E
         8'hAC, 8'hAD, 8'hAE, 8'hAF: g = 7'h69; // i
         8'h8C, 8'h8D, 8'h8E, 8'h8F: g = 7'h49; // I
         8'hB2, 8'hB3, 8'hB4, 8'hB6: g = 7'h6F; // o
         8'h92, 8'h93, 8'h94, 8'h96: g = 7'h4F; // O
         8'hB9, 8'hBA, 8'hBB, 8'hBC: g = 7'h75; // u
         8'h99, 8'h9A, 8'h9B, 8'h9C: g = 7'h55; // U
         8'hB1:                      g = 7'h6E; // n
         8'h91:                      g = 7'h4E; // N
         8'hA7:                      g = 7'h63; // c
         8'h87:                      g = 7'h43; // C
         default:                    g = GLYPH_QUERY;
      endcase
      return g;
   endfunction

   // Punctuation stripped before the ellipsis
   function automatic logic is_trim(input logic [GLYPH_W-1:0] g);
      return g inside {GLYPH_SPACE, GLYPH_COMMA, GLYPH_SEMI, GLYPH_DOT, GLYPH_HYPH};
   endfunction

endpackage

`default_nettype wire

// ===== rtl/utf8ft_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module utf8ft_cell (
   input  wire                       clock,
   input  wire                       reset,
   input  utf8ft_pkg::cell_ctl_type  ctl,
   input  wire                       sel,
   input  wire                       keep_init,
   input  wire                       tok_seed,
   input  utf8ft_pkg::cell_link_type nxt,
   output utf8ft_pkg::cell_link_type cur
);

   logic [utf8ft_pkg::GLYPH_W-1:0] glyph_ff, glyph_in;
   logic                           keep_ff, keep_in;
   logic                           tok_ff, tok_in;
   logic                           trim;

   assign trim = utf8ft_pkg::is_trim(glyph_ff);

   // Cell update: write, mark, trim walk or shift down
   always_comb begin
      glyph_in = glyph_ff;
      keep_in  = keep_ff;
      tok_in   = tok_ff;
      case (ctl.op)
         utf8ft_pkg::CELL_WRITE: begin
            if (sel) begin
               glyph_in = ctl.glyph;
            end
         end
         utf8ft_pkg::CELL_MARK: begin
            tok_in  = tok_seed & trim;
            keep_in = keep_init & ~(tok_seed & trim);
         end
         utf8ft_pkg::CELL_TRIM: begin
            tok_in  = nxt.tok & trim;
            keep_in = keep_ff & ~(nxt.tok & trim);
         end
         utf8ft_pkg::CELL_SHIFT: begin
            glyph_in = nxt.glyph;
            keep_in  = nxt.keep;
            tok_in   = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         keep_ff <= 1'b0;
         tok_ff  <= 1'b0;
      end else begin
         keep_ff <= keep_in;
         tok_ff  <= tok_in;
      end
   end

   // Glyph payload, no reset
   always_ff @(posedge clock) begin
      glyph_ff <= glyph_in;
   end

   assign cur.glyph = glyph_ff;
   assign cur.keep  = keep_ff;
   assign cur.tok   = tok_ff;

endmodule

`default_nettype wire

// ===== rtl/utf8ft_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module utf8ft_ctrl (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_stall,
   input  wire  [utf8ft_pkg::BYTE_W-1:0]       req_in_byte,
   output logic                                rsp_valid,
   input  wire                                 rsp_stall,
   output logic [utf8ft_pkg::GLYPH_W-1:0]      rsp_glyph,
   output logic                                rsp_last,
   output logic                                rsp_empty_res,
   input  wire                                 csr_valid,
   output logic                                csr_ready,
   input  wire  [utf8ft_pkg::CFG_W-1:0]        csr_max_glyphs,
   output utf8ft_pkg::chain_cmd_type           cmd,
   input  utf8ft_pkg::chain_stat_type          stat
);

   localparam int CNT_W = utf8ft_pkg::CNT_W;
   localparam int IDX_W = utf8ft_pkg::IDX_W;

   utf8ft_pkg::state_type                 state_ff, state_in;
   logic [CNT_W-1:0]                      count_ff, count_in;
   logic                                  pend_ff, pend_in;
   logic                                  skip_ff, skip_in;
   logic                                  ovf_ff, ovf_in;
   logic [utf8ft_pkg::CFG_W-1:0]          max_ff, max_in;
   logic                                  rsp_valid_ff, rsp_valid_in;
   logic [utf8ft_pkg::GLYPH_W-1:0]        rsp_glyph_ff, rsp_glyph_in;
   logic                                  rsp_last_ff, rsp_last_in;
   logic                                  rsp_empty_ff, rsp_empty_in;

   logic [CNT_W-1:0]                      lim, cut0;
   logic                                  take, is_nul, is_cont, fit, none;
   logic                                  out_free, beat_load;
   logic                                  write_ok;
   logic [utf8ft_pkg::GLYPH_W-1:0]        fold_glyph;
   logic [IDX_W-1:0]                      wr_idx;

   // Limit and cut point
   assign lim = (max_ff > utf8ft_pkg::CFG_W'(utf8ft_pkg::MAX_COLS))
              ? CNT_W'(utf8ft_pkg::MAX_COLS) : CNT_W'(max_ff);
   assign cut0 = (lim > CNT_W'(2)) ? lim - CNT_W'(2) : '0;
   assign fit  = (count_ff <= lim);
   assign none = (lim == '0) || (count_ff == '0);

   assign take     = req_valid && (state_ff == utf8ft_pkg::ST_IDLE);
   assign is_nul   = (req_in_byte == utf8ft_pkg::BYTE_NUL);
   assign is_cont  = (req_in_byte[7:6] == utf8ft_pkg::CONT_TAG);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Folding of one byte
   always_comb begin
      if (pend_ff) begin
         fold_glyph = utf8ft_pkg::fold_latin(req_in_byte);
      end else if (req_in_byte < utf8ft_pkg::BYTE_HIGH) begin
         fold_glyph = (req_in_byte >= utf8ft_pkg::BYTE_PRINT)
                    ? req_in_byte[utf8ft_pkg::GLYPH_W-1:0] : utf8ft_pkg::GLYPH_SPACE;
      end else begin
         fold_glyph = utf8ft_pkg::GLYPH_QUERY;
      end
   end

   // A pending lead patches the glyph before the count
   assign wr_idx   = pend_ff ? IDX_W'(count_ff - CNT_W'(1)) : IDX_W'(count_ff);
   assign write_ok = pend_ff || (!(skip_ff && is_cont) && fit);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         utf8ft_pkg::ST_IDLE: begin
            if (take && is_nul) begin
               if (none) begin
                  state_in = utf8ft_pkg::ST_EMPTY;
               end else if (fit) begin
                  state_in = utf8ft_pkg::ST_EMIT;
               end else begin
                  state_in = utf8ft_pkg::ST_TRIM;
               end
            end
         end
         utf8ft_pkg::ST_TRIM: begin
            if (!stat.tok_any) begin
               state_in = utf8ft_pkg::ST_EMIT;
            end
         end
         utf8ft_pkg::ST_EMIT: begin
            if (out_free) begin
               if (stat.keep0) begin
                  if (!ovf_ff && !stat.keep1) begin
                     state_in = utf8ft_pkg::ST_IDLE;
                  end
               end else begin
                  state_in = utf8ft_pkg::ST_DOT;
               end
            end
         end
         utf8ft_pkg::ST_DOT, utf8ft_pkg::ST_EMPTY: begin
            if (out_free) begin
               state_in = utf8ft_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = utf8ft_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs: chain command and result beat
   always_comb begin
      cmd.op        = utf8ft_pkg::CELL_HOLD;
      cmd.glyph     = fold_glyph;
      cmd.wr_idx    = wr_idx;
      cmd.mark_n    = fit ? count_ff : cut0;
      cmd.mark_trim = !fit;
      beat_load     = 1'b0;
      rsp_glyph_in  = rsp_glyph_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_empty_in  = rsp_empty_ff;
      case (state_ff)
         utf8ft_pkg::ST_IDLE: begin
            if (take) begin
               if (is_nul) begin
                  cmd.op = utf8ft_pkg::CELL_MARK;
               end else if (write_ok) begin
                  cmd.op = utf8ft_pkg::CELL_WRITE;
               end
            end
         end
         utf8ft_pkg::ST_TRIM: begin
            if (stat.tok_any) begin
               cmd.op = utf8ft_pkg::CELL_TRIM;
            end
         end
         utf8ft_pkg::ST_EMIT: begin
            if (out_free) begin
               beat_load    = 1'b1;
               rsp_empty_in = 1'b0;
               if (stat.keep0) begin
                  cmd.op       = utf8ft_pkg::CELL_SHIFT;
                  rsp_glyph_in = stat.glyph0;
                  rsp_last_in  = !ovf_ff && !stat.keep1;
               end else begin
                  rsp_glyph_in = utf8ft_pkg::GLYPH_DOT;
                  rsp_last_in  = 1'b0;
               end
            end
         end
         utf8ft_pkg::ST_DOT: begin
            if (out_free) begin
               beat_load    = 1'b1;
               rsp_glyph_in = utf8ft_pkg::GLYPH_DOT;
               rsp_last_in  = 1'b1;
               rsp_empty_in = 1'b0;
            end
         end
         utf8ft_pkg::ST_EMPTY: begin
            if (out_free) begin
               beat_load    = 1'b1;
               rsp_glyph_in = utf8ft_pkg::GLYPH_NONE;
               rsp_last_in  = 1'b1;
               rsp_empty_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // String state: count, pending lead, continuation skip, overflow, limit
   always_comb begin
      count_in = count_ff;
      pend_in  = pend_ff;
      skip_in  = skip_ff;
      ovf_in   = ovf_ff;
      max_in   = csr_valid ? csr_max_glyphs : max_ff;
      if (take) begin
         if (is_nul) begin
            count_in = '0;
            pend_in  = 1'b0;
            skip_in  = 1'b0;
            ovf_in   = !fit;
         end else if (pend_ff) begin
            pend_in = 1'b0;
         end else if (!(skip_ff && is_cont)) begin
            skip_in = 1'b0;
            if (fit) begin
               count_in = count_ff + CNT_W'(1);
               if (req_in_byte == utf8ft_pkg::BYTE_LEAD_C3) begin
                  pend_in = 1'b1;
               end else if (req_in_byte >= utf8ft_pkg::BYTE_HIGH) begin
                  skip_in = 1'b1;
               end
            end
         end
      end
   end

   // Output register holds its beat while stalled
   assign rsp_valid_in = beat_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= utf8ft_pkg::ST_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         skip_ff      <= 1'b0;
         ovf_ff       <= 1'b0;
         max_ff       <= utf8ft_pkg::MAX_GLYPHS_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         skip_ff      <= skip_in;
         ovf_ff       <= ovf_in;
         max_ff       <= max_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_glyph_ff <= rsp_glyph_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   assign req_stall     = (state_ff != utf8ft_pkg::ST_IDLE);
   assign csr_ready     = 1'b1;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_glyph     = rsp_glyph_ff;
   assign rsp_last      = rsp_last_ff;
   assign rsp_empty_res = rsp_empty_ff;

endmodule

`default_nettype wire

// ===== rtl/utf8_fold_and_truncate_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// UTF-8 to ASCII fold with truncation.
// req_ channel: one string byte per beat, a zero byte ends the string.
// rsp_ channel: one ASCII glyph per beat, rsp_last on the final glyph of a
// string; an empty result is one beat with rsp_empty_res and rsp_last set.
// csr_ channel: writes max_glyphs (always ready, reset value 21); write it
// only while no string is in flight.
// Non-zero bytes are taken while the block is idle and written straight into a
// row of glyph cells. The zero byte turns the block busy (req_stall high) until
// the last beat has entered the output register: a string that fits is marked
// in the cells by the terminator, then streamed from cell 0 through the output
// register one beat per cycle while rsp_stall does not hold it. A truncated
// string first walks the trailing punctuation down the cell row, one cell per
// cycle, then streams the kept cells and "..".
// Under rsp_stall a valid beat holds and no cell shifts; the walk goes on.
// Reset is synchronous; it empties the string state and drops any pending
// result, cell glyphs are left as they were but their flags are cleared.

module utf8_fold_and_truncate_top (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_valid,
   output logic                           req_stall,
   input  wire  [utf8ft_pkg::BYTE_W-1:0]  req_in_byte,
   output logic                           rsp_valid,
   input  wire                            rsp_stall,
   output logic [utf8ft_pkg::GLYPH_W-1:0] rsp_glyph,
   output logic                           rsp_last,
   output logic                           rsp_empty_res,
   input  wire                            csr_valid,
   output logic                           csr_ready,
   input  wire  [utf8ft_pkg::CFG_W-1:0]   csr_max_glyphs
);

   localparam int CELLS = utf8ft_pkg::CELLS;

   utf8ft_pkg::chain_cmd_type  cmd;
   utf8ft_pkg::chain_stat_type stat;
   utf8ft_pkg::cell_ctl_type   ctl;
   utf8ft_pkg::cell_link_type  links [CELLS];
   logic [CELLS-1:0]           tok_vec;

   utf8ft_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_in_byte   (req_in_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_glyph     (rsp_glyph),
      .rsp_last      (rsp_last),
      .rsp_empty_res (rsp_empty_res),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_max_glyphs(csr_max_glyphs),
      .cmd           (cmd),
      .stat          (stat)
   );

   assign ctl.op    = cmd.op;
   assign ctl.glyph = cmd.glyph;

   // Row of glyph cells, cell 0 faces the output
   for (genvar i = 0; i < CELLS; i++) begin : g_cell
      utf8ft_pkg::cell_link_type nxt;
      logic                      sel, keep_init, tok_seed;

      if (i == CELLS - 1) begin : g_end
         assign nxt = '0;
      end else begin : g_mid
         assign nxt = links[i+1];
      end

      // Per-cell address decode
      assign sel       = (cmd.wr_idx == utf8ft_pkg::IDX_W'(i));
      assign keep_init = (cmd.mark_n > utf8ft_pkg::CNT_W'(i));
      assign tok_seed  = cmd.mark_trim && (cmd.mark_n == utf8ft_pkg::CNT_W'(i + 1));

      utf8ft_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .sel      (sel),
         .keep_init(keep_init),
         .tok_seed (tok_seed),
         .nxt      (nxt),
         .cur      (links[i])
      );

      assign tok_vec[i] = links[i].tok;
   end

   assign stat.glyph0  = links[0].glyph;
   assign stat.keep0   = links[0].keep;
   assign stat.keep1   = links[1].keep;
   assign stat.tok_any = |tok_vec;

endmodule

`default_nettype wire

// ===== rtl/utf8ft_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "utf8_fold_and_truncate_top_assert.svh"

module utf8ft_checker (
   input wire                            clock,
   input wire                            reset,
   input wire                            req_valid,
   input wire                            req_stall,
   input wire [utf8ft_pkg::BYTE_W-1:0]   req_in_byte,
   input wire                            rsp_valid,
   input wire                            rsp_stall,
   input wire [utf8ft_pkg::GLYPH_W-1:0]  rsp_glyph,
   input wire                            rsp_last,
   input wire                            rsp_empty_res,
   input wire                            csr_valid,
   input wire                            csr_ready,
   input wire [utf8ft_pkg::CFG_W-1:0]    csr_max_glyphs
);

   // A stalled result beat stays put
   `UFT_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_glyph) && $stable(rsp_last) && $stable(rsp_empty_res), "result beat changed under stall")

   // An empty result is always the closing beat
   `UFT_ASSERT_NOW(a_empty_last, rsp_valid && rsp_empty_res, rsp_last, "empty beat without last")

   // Real glyphs are not below space
   `UFT_ASSERT_NOW(a_glyph_range, rsp_valid && !rsp_empty_res, rsp_glyph >= utf8ft_pkg::GLYPH_SPACE, "glyph below space")

   // A terminator makes the block busy on the next cycle
   `UFT_ASSERT_NEXT(a_nul_busy, req_valid && !req_stall && (req_in_byte == utf8ft_pkg::BYTE_NUL), req_stall, "block idle after terminator")

   // Configuration is never back-pressured
   `UFT_ASSERT_NOW(a_csr_ready, csr_valid, csr_ready, "configuration write refused")

endmodule

bind utf8_fold_and_truncate_top utf8ft_checker u_checker (.*);

`default_nettype wire
